// File: rtl/sensor_frame_dashboard_assert.svh
// ----------------------------------------------------------------------------
// Sensor frame dashboard assertion macros
// Shorthand for clocked checks with the reset disable built in.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_DASHBOARD_ASSERT_SVH
`define SENSOR_FRAME_DASHBOARD_ASSERT_SVH

// same-cycle implication
`define SFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfd check failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfd check failed");

`endif

// File: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and helper functions shared by the dashboard modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int FRAME_LEN   = 6;
    localparam int NUM_DIGITS  = 10;
    localparam int VAL_W       = 14;
    localparam int Q_DEPTH     = 2;

    localparam logic [1:0] OP_SENSOR = 2'd0;
    localparam logic [1:0] OP_MODE   = 2'd1;
    localparam logic [1:0] OP_BUTTON = 2'd2;

    localparam logic [7:0] MODE_MON = 8'h6D;
    localparam logic [7:0] MODE_DRV = 8'h64;
    localparam logic [7:0] MODE_SPD = 8'h73;
    localparam logic [7:0] MODE_OFF = 8'h6F;

    localparam logic [7:0] BTN_MON = 8'h80;
    localparam logic [7:0] BTN_DRV = 8'h40;
    localparam logic [7:0] BTN_SPD = 8'h20;

    localparam logic [7:0] LINK_RESTART = 8'h00;
    localparam logic [7:0] LINK_SHOW    = 8'hFF;

    localparam logic [7:0]  COOLANT_LIMIT_RST = 8'd110;
    localparam logic [15:0] REVS_LIMIT_RST    = 16'd6000;
    localparam logic [15:0] REVS_SHOWN_MAX    = 16'd9999;

    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_ON    = 2'd1;
    localparam logic [1:0] LED_ALARM = 2'd2;

    localparam logic       CFG_COOLANT = 1'b0;
    localparam logic       CFG_REVS    = 1'b1;

    localparam logic [3:0] DIGIT_MODE  = 4'd0;
    localparam logic [3:0] DIGIT_SPACE = 4'd5;
    localparam logic [3:0] DIGIT_LAST  = 4'd9;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0] digit_index;
        logic [6:0] segments;
        logic [1:0] led_state;
        logic       last_digit;
    } out_item_t;

    typedef struct packed {
        logic [1:0]       mode_digit;
        logic [VAL_W-1:0] first_val;
        logic [7:0]       second_val;
        logic [1:0]       led;
    } show_cmd_t;

    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] p;
        begin
            case (d)
                4'd0:    p = 7'h3F;
                4'd1:    p = 7'h06;
                4'd2:    p = 7'h5B;
                4'd3:    p = 7'h4F;
                4'd4:    p = 7'h66;
                4'd5:    p = 7'h6D;
                4'd6:    p = 7'h7D;
                4'd7:    p = 7'h07;
                4'd8:    p = 7'h7F;
                4'd9:    p = 7'h6F;
                default: p = 7'h3F;
            endcase
            return p;
        end
    endfunction

    // decimal weight of a display position inside its 4-digit group
    function automatic logic [VAL_W-1:0] place_weight(input logic [3:0] idx);
        logic [VAL_W-1:0] w;
        begin
            case (idx)
                4'd1, 4'd6: w = VAL_W'(1000);
                4'd2, 4'd7: w = VAL_W'(100);
                4'd3, 4'd8: w = VAL_W'(10);
                default:    w = VAL_W'(1);
            endcase
            return w;
        end
    endfunction

endpackage

// File: rtl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Accepts input items, keeps frame and mode state, and issues show commands.
// ----------------------------------------------------------------------------
module sfd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sfd_pkg::in_item_t  in_data,
    input  logic [7:0]         coolant_limit,
    input  logic [15:0]        revs_limit,
    input  logic               q_full,
    output logic               q_push,
    output sfd_pkg::show_cmd_t q_wdata
);
    import sfd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  mode_reg, mode_next;
    logic [7:0]  bytes_reg [FRAME_LEN];
    logic        accept, full, store;
    logic [15:0] revs;
    logic [VAL_W-1:0] revs_shown;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign full     = (pos_reg == 3'(FRAME_LEN));
    assign store    = accept && (in_data.opcode == OP_SENSOR) && !full;
    assign q_push   = accept && (in_data.opcode == OP_SENSOR) && full
                      && (in_data.data_byte == LINK_SHOW);

    always_comb
    begin
        pos_next  = pos_reg;
        mode_next = mode_reg;
        if (accept)
        begin
            case (in_data.opcode)
                OP_SENSOR:
                begin
                    if (!full)
                        pos_next = pos_reg + 3'd1;
                    else if (in_data.data_byte == LINK_RESTART)
                        pos_next = 3'd0;
                    else if (in_data.data_byte != LINK_SHOW)
                        mode_next = MODE_OFF;
                end
                OP_MODE:
                    mode_next = in_data.data_byte;
                OP_BUTTON:
                begin
                    case (in_data.data_byte)
                        BTN_MON: mode_next = MODE_MON;
                        BTN_DRV: mode_next = MODE_DRV;
                        BTN_SPD: mode_next = MODE_SPD;
                        default: mode_next = MODE_OFF;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        revs       = {bytes_reg[2], bytes_reg[3]};
        revs_shown = (revs > REVS_SHOWN_MAX) ? REVS_SHOWN_MAX[VAL_W-1:0] : revs[VAL_W-1:0];
        q_wdata    = '0;
        case (mode_reg)
            MODE_MON:
            begin
                q_wdata.mode_digit = 2'd1;
                q_wdata.first_val  = VAL_W'(bytes_reg[1]);
                q_wdata.second_val = bytes_reg[0];
            end
            MODE_DRV:
            begin
                q_wdata.mode_digit = 2'd2;
                q_wdata.first_val  = revs_shown;
                q_wdata.second_val = bytes_reg[4];
            end
            MODE_SPD:
            begin
                q_wdata.mode_digit = 2'd3;
                q_wdata.first_val  = revs_shown;
                q_wdata.second_val = bytes_reg[5];
            end
            default: ;
        endcase
        if (q_wdata.mode_digit != 2'd0)
            q_wdata.led = ((bytes_reg[1] > coolant_limit) || (revs > revs_limit))
                          ? LED_ALARM : LED_ON;
        else
            q_wdata.led = LED_OFF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 3'd0;
            mode_reg <= MODE_OFF;
        end
        else
        begin
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
            bytes_reg[pos_reg] <= in_data.data_byte;
    end

endmodule

// File: rtl/sfd_queue.sv
// ----------------------------------------------------------------------------
// sfd_queue
// Two-entry FIFO of show commands between the front and back ends.
// ----------------------------------------------------------------------------
module sfd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sfd_pkg::show_cmd_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               rvalid,
    output sfd_pkg::show_cmd_t rdata
);
    import sfd_pkg::*;

    show_cmd_t  mem_reg [Q_DEPTH];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;

    assign full   = (count_reg == 2'(Q_DEPTH));
    assign rvalid = (count_reg != 2'd0);
    assign rdata  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// File: rtl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Turns one show command into ten digit transfers, one decimal digit a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sfd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  sfd_pkg::show_cmd_t  q_rdata,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output sfd_pkg::out_item_t  out_data
);
    import sfd_pkg::*;

    show_cmd_t        cmd_reg;
    logic             busy_reg, busy_next;
    logic [3:0]       idx_reg, idx_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic             out_valid_reg;
    out_item_t        out_reg, out_next;
    logic             advance, produce, load;
    logic [VAL_W-1:0] weight;
    logic [3:0]       quot, digit;

    assign advance = !out_valid_reg || !out_stall;
    assign produce = busy_reg && advance;
    assign load    = q_valid && (!busy_reg || (produce && idx_reg == DIGIT_LAST));
    assign q_pop   = load;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        weight = place_weight(idx_reg);
        quot   = 4'd0;
        for (int d = 1; d < 10; d++)
        begin
            if (int'(rem_reg) >= d * int'(weight))
                quot = 4'(d);
        end
        case (idx_reg)
            DIGIT_MODE:
            begin
                digit    = {2'b00, cmd_reg.mode_digit};
                rem_next = VAL_W'(cmd_reg.second_val);
            end
            DIGIT_SPACE:
            begin
                digit    = 4'd0;
                rem_next = cmd_reg.first_val;
            end
            default:
            begin
                digit    = quot;
                rem_next = rem_reg - VAL_W'(int'(quot) * int'(weight));
            end
        endcase
        out_next.digit_index = idx_reg;
        out_next.segments    = seg_pattern(digit);
        out_next.led_state   = cmd_reg.led;
        out_next.last_digit  = (idx_reg == DIGIT_LAST);
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (produce)
        begin
            idx_next = idx_reg + 4'd1;
            if (idx_reg == DIGIT_LAST)
                busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = DIGIT_MODE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (advance)
                out_valid_reg <= produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= q_rdata;
        if (produce)
        begin
            rem_reg <= rem_next;
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/sensor_frame_dashboard.sv
// ----------------------------------------------------------------------------
// sensor_frame_dashboard
// Sensor link frame decoder driving a ten-digit seven-segment dashboard.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): one sensor byte, mode
// character or button byte per transfer. Items that cause no display
// output are taken one per cycle while the command queue is not full.
// A show byte on a full frame queues a display command; ten digit transfers
// follow on the output channel (out_valid / out_stall / out_data), digit 0
// first, after the command passes the queue, cmd_reg and the output register.
// The back end produces one digit per cycle while out_stall is low;
// a two-entry command queue lets the input keep running meanwhile and
// stalls input only when both entries are taken.
// Config writes (cfg_we, cfg_index, cfg_data) are registered:
// index 0 is the coolant limit (low 8 bits), index 1 the revs limit.
// Reset empties the queue and output, restarts the frame, sets the mode
// to off and loads the default limits. An output stall holds the current
// digit and backs up into the queue.
// ----------------------------------------------------------------------------
module sensor_frame_dashboard (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sfd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sfd_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import sfd_pkg::*;

    `include "sensor_frame_dashboard_assert.svh"

    logic [7:0]  coolant_limit_reg;
    logic [15:0] revs_limit_reg;
    logic        q_full, q_push, q_pop, q_valid;
    show_cmd_t   q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coolant_limit_reg <= COOLANT_LIMIT_RST;
            revs_limit_reg    <= REVS_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COOLANT: coolant_limit_reg <= cfg_data[7:0];
                CFG_REVS:    revs_limit_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    sfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .coolant_limit (coolant_limit_reg),
        .revs_limit    (revs_limit_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    sfd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    sfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `SFD_ASSERT_NOW(a_last_at_nine, out_valid && out_data.last_digit, out_data.digit_index == DIGIT_LAST)
    `SFD_ASSERT_NOW(a_led_code, out_valid, out_data.led_state == LED_OFF || out_data.led_state == LED_ON || out_data.led_state == LED_ALARM)
    `SFD_ASSERT_NEXT(a_frame_unbroken, out_valid && !out_stall && !out_data.last_digit, out_valid)
    `SFD_ASSERT_NOW(a_no_pop_empty, q_pop, q_valid)

endmodule

// File: verif/sfd_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dashboard scoreboard
// Tracks frame, mode and alarm limits as transfers are accepted and keeps
// the digit transfers each show byte should produce, checked in order.
// ----------------------------------------------------------------------------
package sfd_tb_pkg;

    import sfd_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [6:0] GLYPH [0:9] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    class dash_scoreboard;

        logic [7:0]  coolant_limit;
        logic [15:0] revs_limit;
        int unsigned frame_fill;
        logic [7:0]  frame [FRAME_LEN];
        logic [7:0]  mode;
        out_item_t   expected_digits [$];
        int unsigned errors;

        function new();
            coolant_limit = COOLANT_LIMIT_RST;
            revs_limit    = REVS_LIMIT_RST;
            frame_fill    = 0;
            mode          = MODE_OFF;
            errors        = 0;
        endfunction

        function void set_limit(logic index, logic [15:0] value);
            if (index == CFG_COOLANT)
                coolant_limit = value[7:0];
            else
                revs_limit = value;
        endfunction

        function bit frame_full();
            return frame_fill >= FRAME_LEN;
        endfunction

        function int unsigned pending();
            return expected_digits.size();
        endfunction

        function void predict_display();
            logic [3:0]  shown [NUM_DIGITS];
            int unsigned revs;
            int unsigned left_val;
            int unsigned right_val;
            logic [1:0]  led;
            out_item_t   d;
            revs = 32'({frame[2], frame[3]});
            led  = LED_OFF;
            foreach (shown[k])
                shown[k] = 4'd0;
            if (mode == MODE_MON || mode == MODE_DRV || mode == MODE_SPD)
            begin
                led = (frame[1] > coolant_limit || revs > revs_limit) ? LED_ALARM : LED_ON;
                if (mode == MODE_MON)
                begin
                    shown[DIGIT_MODE] = 4'd1;
                    left_val  = 32'(frame[0]);
                    right_val = 32'(frame[1]);
                end
                else
                begin
                    shown[DIGIT_MODE] = (mode == MODE_DRV) ? 4'd2 : 4'd3;
                    left_val  = (mode == MODE_DRV) ? 32'(frame[4]) : 32'(frame[5]);
                    right_val = (revs > 32'(REVS_SHOWN_MAX)) ? 32'(REVS_SHOWN_MAX) : revs;
                end
                for (int k = 0; k < 4; k++)
                begin
                    shown[4 - k] = 4'(left_val % 10);
                    shown[9 - k] = 4'(right_val % 10);
                    left_val  = left_val / 10;
                    right_val = right_val / 10;
                end
            end
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                d.digit_index = 4'(k);
                d.segments    = GLYPH[shown[k]];
                d.led_state   = led;
                d.last_digit  = (4'(k) == DIGIT_LAST);
                expected_digits.push_back(d);
            end
        endfunction

        function void note_transfer(in_item_t item);
            case (item.opcode)
                OP_SENSOR:
                begin
                    if (!frame_full())
                    begin
                        frame[frame_fill] = item.data_byte;
                        frame_fill++;
                    end
                    else if (item.data_byte == LINK_RESTART)
                        frame_fill = 0;
                    else if (item.data_byte == LINK_SHOW)
                        predict_display();
                    else
                        mode = MODE_OFF;
                end
                OP_MODE:
                    mode = item.data_byte;
                OP_BUTTON:
                begin
                    case (item.data_byte)
                        BTN_MON: mode = MODE_MON;
                        BTN_DRV: mode = MODE_DRV;
                        BTN_SPD: mode = MODE_SPD;
                        default: mode = MODE_OFF;
                    endcase
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_digit(out_item_t got);
            out_item_t want;
            if (expected_digits.size() == 0)
            begin
                $error("unexpected digit transfer, digit_index %0d", got.digit_index);
                errors++;
                return;
            end
            want = expected_digits.pop_front();
            compare_field("digit_index", 16'(want.digit_index), 16'(got.digit_index));
            compare_field("segments", 16'(want.segments), 16'(got.segments));
            compare_field("led_state", 16'(want.led_state), 16'(got.led_state));
            compare_field("last_digit", 16'(want.last_digit), 16'(got.last_digit));
        endfunction

    endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame dashboard testbench
// Directed frames through every mode and link case, then random frame
// traffic under several alarm limits with random gaps and output stalls,
// including a long output hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    import sfd_pkg::*;
    import sfd_tb_pkg::*;

    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 12;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    dash_scoreboard sb;
    int unsigned    items_sent;
    int unsigned    digits_taken;
    bit             sender_calm;
    bit             receiver_calm;

    sensor_frame_dashboard DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_digit(out_data);
    end

    task automatic send_item(logic [1:0] op, logic [7:0] value);
        in_item_t    item;
        int unsigned gap;
        item.opcode    = op;
        item.data_byte = value;
        gap = sender_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_transfer(item);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic set_limits(logic [15:0] coolant, logic [15:0] revs);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COOLANT;
        cfg_data  <= coolant;
        @(posedge clk);
        sb.set_limit(CFG_COOLANT, coolant);
        cfg_index <= CFG_REVS;
        cfg_data  <= revs;
        @(posedge clk);
        sb.set_limit(CFG_REVS, revs);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_mode_cmd();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       send_item(OP_BUTTON, BTN_MON);
            1:       send_item(OP_BUTTON, BTN_DRV);
            2:       send_item(OP_BUTTON, BTN_SPD);
            3:       send_item(OP_BUTTON, BTN_MON);
            4:       send_item(OP_BUTTON, 8'($urandom));
            5:       send_item(OP_MODE, MODE_MON);
            6:       send_item(OP_MODE, MODE_DRV);
            7:       send_item(OP_MODE, MODE_SPD);
            8:       send_item(OP_MODE, MODE_OFF);
            default: send_item(OP_MODE, 8'($urandom));
        endcase
    endtask

    task automatic run_directed();
        send_item(OP_SENSOR, 8'hFF);
        send_item(OP_SENSOR, 8'h00);
        send_item(OP_SENSOR, 8'hFF);
        send_item(OP_SENSOR, 8'hFF);
        send_item(OP_SENSOR, 8'h00);
        send_item(OP_SENSOR, 8'hFF);
        send_item(OP_SENSOR, LINK_SHOW);
        send_item(OP_BUTTON, BTN_MON);
        send_item(OP_SENSOR, LINK_SHOW);
        send_item(OP_BUTTON, BTN_DRV);
        send_item(OP_SENSOR, LINK_SHOW);
        send_item(OP_MODE, MODE_SPD);
        send_item(OP_UNUSED, BTN_MON);
        send_item(OP_SENSOR, LINK_SHOW);
        send_item(OP_SENSOR, 8'h5A);
        send_item(OP_SENSOR, LINK_RESTART);
        send_item(OP_SENSOR, 8'h00);
        send_item(OP_SENSOR, 8'd111);
        send_item(OP_SENSOR, REVS_LIMIT_RST[15:8]);
        send_item(OP_SENSOR, REVS_LIMIT_RST[7:0]);
        send_item(OP_SENSOR, 8'h09);
        send_item(OP_SENSOR, 8'h63);
        send_item(OP_BUTTON, 8'h60);
        send_item(OP_SENSOR, LINK_SHOW);
        send_item(OP_BUTTON, BTN_SPD);
        send_item(OP_SENSOR, LINK_SHOW);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned goal;
        int unsigned pick;
        int unsigned shows;
        logic [7:0]  coolant;
        logic [15:0] revs;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            sender_calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 3)
            begin
                repeat ($urandom_range(1, 3))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
            else if (pick < 7)
                send_mode_cmd();
            else
            begin
                if (pick < 14)
                    send_mode_cmd();
                if (sb.frame_full() && $urandom_range(0, 4) != 0)
                    send_item(OP_SENSOR, LINK_RESTART);
                if (!sb.frame_full())
                begin
                    case ($urandom_range(0, 3))
                        0:       coolant = sb.coolant_limit + 8'($urandom_range(0, 2)) - 8'd1;
                        default: coolant = 8'($urandom);
                    endcase
                    case ($urandom_range(0, 4))
                        0:       revs = sb.revs_limit + 16'($urandom_range(0, 2)) - 16'd1;
                        1:       revs = REVS_SHOWN_MAX + 16'($urandom_range(0, 2)) - 16'd1;
                        2:       revs = 16'($urandom_range(0, 9999));
                        default: revs = 16'($urandom);
                    endcase
                    send_item(OP_SENSOR, 8'($urandom));
                    send_item(OP_SENSOR, coolant);
                    send_item(OP_SENSOR, revs[15:8]);
                    send_item(OP_SENSOR, revs[7:0]);
                    send_item(OP_SENSOR, 8'($urandom));
                    send_item(OP_SENSOR, 8'($urandom));
                end
                shows = $urandom_range(1, 3);
                repeat (shows) send_item(OP_SENSOR, LINK_SHOW);
            end
        end
    endtask

    // output side: random stalls per digit, calm stretches, two long holds
    initial
    begin
        int unsigned wait_cycles;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (digits_taken % 32 == 0)
                receiver_calm = ($urandom_range(0, 3) == 0);
            if (digits_taken == 50 || digits_taken == 450)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            wait_cycles = receiver_calm ? 0 : $urandom_range(0, 7);
            if (wait_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            digits_taken++;
        end
    end

    initial
    begin
        #800000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        sb            = new();
        items_sent    = 0;
        digits_taken  = 0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_COOLANT;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset limits
        run_directed();
        run_random(70);
        settle();

        // lowest limits, upper coolant bits must be ignored
        set_limits(16'hA500, 16'h0000);
        run_random(70);
        settle();

        // highest limits
        set_limits(16'h00FF, 16'hFFFF);
        run_random(70);
        settle();

        set_limits(16'($urandom), 16'($urandom_range(0, 12000)));
        run_random(70);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
